FILE: design/shrc_pkg.sv
// Shared types, codes and constants of the servo hold and release controller.
`timescale 1ns / 1ps

package shrc_pkg;

  // Default widths of the value path and of the release timer.
  localparam int VALUE_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF = 16;

  // Fixed field widths.
  localparam int ANGLE_BITS     = 8;
  localparam int MODE_BITS      = 3;
  localparam int FUNC_BITS      = 3;
  localparam int REG_IDX_BITS   = 3;
  localparam int OUT_TDATA_BITS = 16;

  // Command codes carried in the input tuser.
  localparam logic [FUNC_BITS-1:0] FUNC_TICK      = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SET_ANGLE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_SET_VALUE = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_GO_MIN    = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_GO_MAX    = 3'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_START     = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_BITS-1:0] REG_MODE          = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_LO_LIMIT      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_HI_LIMIT      = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_NEUTRAL_ANGLE = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_VALUE_LOW     = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_VALUE_HIGH    = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_TICKS = 3'd6;

  // Bit positions inside the mode register.
  localparam int MODE_ENABLE        = 0;
  localparam int MODE_NEUTRAL_START = 1;
  localparam int MODE_NEUTRAL_MOVE  = 2;

  // Register reset values.
  localparam logic [ANGLE_BITS-1:0] HI_LIMIT_RST      = 8'd180;
  localparam logic [ANGLE_BITS-1:0] NEUTRAL_ANGLE_RST = 8'd90;
  localparam int                    VALUE_HIGH_RST    = 1000;

  // One result word, fields listed from the highest bit down as on the output tdata.
  typedef struct packed {
    logic                  scale_fault;
    logic                  position_flag;
    logic                  angle_written;
    logic                  drive_on;
    logic [ANGLE_BITS-1:0] drive_angle;
  } shrc_result_t;

endpackage

FILE: design/shrc_scaler.sv
// Bit-serial multiply and divide unit that maps a raw value onto the angle range.
`timescale 1ns / 1ps

module shrc_scaler
  import shrc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [ANGLE_BITS:0]   span_i,     // upper limit - lower limit
  input  logic signed [VALUE_BITS:0]   delta_i,    // operand - value_low
  input  logic signed [VALUE_BITS:0]   divisor_i,  // value_high - value_low, never zero
  input  logic        [ANGLE_BITS-1:0] base_i,     // lower angle limit
  output logic                         done_o,
  output logic        [VALUE_BITS-1:0] result_o
);

  // Product and quotient share one shift register of this width.
  localparam int PW = VALUE_BITS + ANGLE_BITS;
  localparam int CW = $clog2(PW);

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_MUL  = 5'b00010,
    SC_DIV  = 5'b00100,
    SC_FIX  = 5'b01000,
    SC_DONE = 5'b10000
  } sc_state_e;

  sc_state_e              st_q, st_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [PW-1:0]          p_q, p_d;
  logic [VALUE_BITS-1:0]  r_q, r_d;
  logic [ANGLE_BITS-1:0]  mag_a_q, mag_a_d;
  logic [VALUE_BITS-1:0]  div_q, div_d;
  logic                   neg_q, neg_d;
  logic [ANGLE_BITS-1:0]  base_q, base_d;
  logic [VALUE_BITS-1:0]  res_q, res_d;

  logic [ANGLE_BITS:0]    span_abs;
  logic [VALUE_BITS:0]    delta_abs;
  logic [VALUE_BITS:0]    divisor_abs;
  logic [ANGLE_BITS:0]    mul_sum;
  logic [VALUE_BITS:0]    r_sh;
  logic [VALUE_BITS:0]    r_sub;
  logic                   q_bit;
  logic signed [PW:0]     q_s;
  logic signed [PW+1:0]   t_s;

  // Saturation bounds of the signed value range, at the width of the sum.
  localparam logic signed [PW+1:0] SAT_HI =
    {{(PW + 3 - VALUE_BITS){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [PW+1:0] SAT_LO =
    {{(PW + 3 - VALUE_BITS){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

  // Magnitudes of the operands; all of them fit one bit less than their inputs.
  assign span_abs    = span_i[ANGLE_BITS] ? (-span_i) : span_i;
  assign delta_abs   = delta_i[VALUE_BITS] ? (-delta_i) : delta_i;
  assign divisor_abs = divisor_i[VALUE_BITS] ? (-divisor_i) : divisor_i;

  // Shift-add multiply step: one multiplier bit per cycle, narrow adder on the top.
  assign mul_sum = {1'b0, p_q[PW-1:VALUE_BITS]} +
                   (p_q[0] ? {1'b0, mag_a_q} : {(ANGLE_BITS + 1){1'b0}});

  // Restoring divide step: one quotient bit per cycle.
  assign r_sh  = {r_q, p_q[PW-1]};
  assign q_bit = (r_sh >= {1'b0, div_q});
  assign r_sub = r_sh - {1'b0, div_q};

  // Sign, offset and saturation of the quotient.
  assign q_s = neg_q ? (-$signed({1'b0, p_q})) : $signed({1'b0, p_q});
  assign t_s = $signed({q_s[PW], q_s}) + $signed({{(PW + 2 - ANGLE_BITS){1'b0}}, base_q});

  // Sequencer and datapath next state.
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    r_d     = r_q;
    mag_a_d = mag_a_q;
    div_d   = div_q;
    neg_d   = neg_q;
    base_d  = base_q;
    res_d   = res_q;
    unique case (st_q)
      SC_IDLE: begin
        if (start_i) begin
          mag_a_d = span_abs[ANGLE_BITS-1:0];
          div_d   = divisor_abs[VALUE_BITS-1:0];
          neg_d   = span_i[ANGLE_BITS] ^ delta_i[VALUE_BITS] ^ divisor_i[VALUE_BITS];
          base_d  = base_i;
          p_d     = {{ANGLE_BITS{1'b0}}, delta_abs[VALUE_BITS-1:0]};
          cnt_d   = '0;
          st_d    = SC_MUL;
        end
      end
      SC_MUL: begin
        p_d   = {mul_sum, p_q[VALUE_BITS-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(VALUE_BITS - 1)) begin
          cnt_d = '0;
          r_d   = '0;
          st_d  = SC_DIV;
        end
      end
      SC_DIV: begin
        p_d   = {p_q[PW-2:0], q_bit};
        r_d   = q_bit ? r_sub[VALUE_BITS-1:0] : r_sh[VALUE_BITS-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          st_d = SC_FIX;
        end
      end
      SC_FIX: begin
        if (t_s > SAT_HI) begin
          res_d = SAT_HI[VALUE_BITS-1:0];
        end else if (t_s < SAT_LO) begin
          res_d = SAT_LO[VALUE_BITS-1:0];
        end else begin
          res_d = t_s[VALUE_BITS-1:0];
        end
        st_d = SC_DONE;
      end
      SC_DONE: begin
        st_d = SC_IDLE;
      end
      default: begin
        st_d = SC_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SC_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    r_q     <= r_d;
    mag_a_q <= mag_a_d;
    div_q   <= div_d;
    neg_q   <= neg_d;
    base_q  <= base_d;
    res_q   <= res_d;
  end

  assign done_o   = (st_q == SC_DONE);
  assign result_o = res_q;

  // A new job only starts when the unit is free.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (st_q == SC_IDLE))
    else $error("scaler started while busy");

  // A zero divisor is filtered out before the unit is started.
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (divisor_i != '0))
    else $error("scaler started with a zero divisor");

  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SC_DIV) |=> (r_q < div_q))
    else $error("divider remainder out of range");

endmodule

FILE: design/servo_hold_release_controller_top.sv
// Top level of the servo hold and release controller: registers, command handling, output.
`timescale 1ns / 1ps

// One servo channel. Each input word carries a command code in s_axis_tuser_i and
// an operand in s_axis_tdata_i; each accepted word yields exactly one result word on
// the m_axis side with the drive angle and status flags.
// Ticks and all commands except a set value that starts the scaling unit are handled
// in the cycle they are accepted, and the result is registered for the m_axis side.
// Such a set value runs through a bit-serial multiply and divide unit: a shift-add
// multiply, a restoring division, a sign fix with saturation and a hand-over step
// before its result is registered in the same way. The block takes one word at a
// time; s_axis_tready_o is high whenever no word is in flight.
// A finished result waits in the output register while the block already accepts
// the next word; if that word's result is ready before the receiver takes the first
// one, it is parked in a hold register and s_axis_tready_o stays low until it moves.
// Configuration writes on cfg_we_i take effect at once and are meant for idle time.
// Reset clears all channel state, loads the register defaults and empties the output.

module servo_hold_release_controller_top
  import shrc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,   // operand
  input  logic [FUNC_BITS-1:0]        s_axis_tuser_i,   // func
  // Output stream.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // drive_angle, drive_on, angle_written, position_flag, scale_fault
  output logic [OUT_TDATA_BITS-1:0]   m_axis_tdata_o,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [((VALUE_BITS > TIMER_BITS) ? VALUE_BITS : TIMER_BITS) - 1:0] cfg_data_i
);

  // The target is one bit wider than a value so that angles up to 255 stay positive.
  localparam int TW            = VALUE_BITS + 1;
  localparam int RESULT_BITS   = $bits(shrc_result_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCALE = 3'b010,
    ST_HOLD  = 3'b100
  } ctl_state_e;

  // Configuration registers.
  logic [MODE_BITS-1:0]         mode_q;
  logic [ANGLE_BITS-1:0]        lo_limit_q;
  logic [ANGLE_BITS-1:0]        hi_limit_q;
  logic [ANGLE_BITS-1:0]        neutral_q;
  logic [VALUE_BITS-1:0]        value_low_q;
  logic [VALUE_BITS-1:0]        value_high_q;
  logic [TIMER_BITS-1:0]        release_ticks_q;

  // Channel state.
  ctl_state_e                   st_q, st_d;
  logic signed [TW-1:0]         target_q, target_d;
  logic [ANGLE_BITS-1:0]        current_q, current_d;
  logic                         attached_q, attached_d;
  logic                         armed_q, armed_d;
  logic [TIMER_BITS-1:0]        count_q, count_d;
  logic                         end_flag_q, end_flag_d;

  // Output side.
  logic                         m_valid_q, m_valid_d;
  shrc_result_t                 m_res_q, m_res_d;
  shrc_result_t                 pend_q, pend_d;

  logic [VALUE_BITS-1:0]        operand;
  logic signed [TW-1:0]         operand_x;
  logic signed [TW-1:0]         min_x, max_x, current_x, neutral_x;
  logic [TIMER_BITS-1:0]        count_dec;
  logic                         enabled;
  logic                         in_fire;
  logic                         out_free;
  logic                         produce;
  logic                         written;
  logic                         fault;
  shrc_result_t                 res;

  logic                         sc_start;
  logic signed [ANGLE_BITS:0]   sc_span;
  logic signed [VALUE_BITS:0]   sc_delta;
  logic signed [VALUE_BITS:0]   sc_divisor;
  logic                         sc_done;
  logic [VALUE_BITS-1:0]        sc_result;

  assign operand   = s_axis_tdata_i[VALUE_BITS-1:0];
  assign operand_x = $signed({operand[VALUE_BITS-1], operand});
  assign min_x     = $signed({{(TW - ANGLE_BITS){1'b0}}, lo_limit_q});
  assign max_x     = $signed({{(TW - ANGLE_BITS){1'b0}}, hi_limit_q});
  assign current_x = $signed({{(TW - ANGLE_BITS){1'b0}}, current_q});
  assign neutral_x = $signed({{(TW - ANGLE_BITS){1'b0}}, neutral_q});
  assign count_dec = (count_q != '0) ? (count_q - 1'b1) : count_q;
  assign enabled   = mode_q[MODE_ENABLE];
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;

  // Operands of the scaling unit.
  assign sc_span    = $signed({1'b0, hi_limit_q}) - $signed({1'b0, lo_limit_q});
  assign sc_delta   = operand_x - $signed({value_low_q[VALUE_BITS-1], value_low_q});
  assign sc_divisor = $signed({value_high_q[VALUE_BITS-1], value_high_q}) -
                      $signed({value_low_q[VALUE_BITS-1], value_low_q});

  shrc_scaler #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scaler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sc_start),
    .span_i    (sc_span),
    .delta_i   (sc_delta),
    .divisor_i (sc_divisor),
    .base_i    (lo_limit_q),
    .done_o    (sc_done),
    .result_o  (sc_result)
  );

  // Command handling and result formation.
  always_comb begin
    st_d       = st_q;
    target_d   = target_q;
    current_d  = current_q;
    attached_d = attached_q;
    armed_d    = armed_q;
    count_d    = count_q;
    end_flag_d = end_flag_q;
    sc_start   = 1'b0;
    produce    = 1'b0;
    written    = 1'b0;
    fault      = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          produce = 1'b1;
          if (enabled) begin
            unique case (s_axis_tuser_i)
              FUNC_TICK: begin
                if (target_q != current_x) begin
                  // Clamp, lower limit first, then drive and reload the countdown.
                  if (target_q < min_x) begin
                    target_d = min_x;
                  end else if (target_q > max_x) begin
                    target_d = max_x;
                  end
                  current_d  = target_d[ANGLE_BITS-1:0];
                  attached_d = 1'b1;
                  written    = 1'b1;
                  count_d    = release_ticks_q;
                  armed_d    = (release_ticks_q != '0);
                end else if (armed_q) begin
                  count_d = count_dec;
                  if (count_dec == '0) begin
                    if (mode_q[MODE_NEUTRAL_MOVE] && (current_q != neutral_q)) begin
                      target_d = neutral_x;
                    end else begin
                      attached_d = 1'b0;
                      armed_d    = 1'b0;
                    end
                  end
                end
              end
              FUNC_SET_ANGLE: begin
                target_d = operand_x;
              end
              FUNC_SET_VALUE: begin
                if (value_high_q == value_low_q) begin
                  fault = 1'b1;
                end else begin
                  produce  = 1'b0;
                  sc_start = 1'b1;
                  st_d     = ST_SCALE;
                end
              end
              FUNC_GO_MIN: begin
                target_d   = min_x;
                end_flag_d = 1'b0;
              end
              FUNC_GO_MAX: begin
                target_d   = max_x;
                end_flag_d = 1'b1;
              end
              FUNC_START: begin
                if (mode_q[MODE_NEUTRAL_START]) begin
                  current_d  = neutral_q;
                  target_d   = neutral_x;
                  attached_d = 1'b1;
                  written    = 1'b1;
                  count_d    = release_ticks_q;
                  armed_d    = (release_ticks_q != '0);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_SCALE: begin
        if (sc_done) begin
          target_d = $signed({sc_result[VALUE_BITS-1], sc_result});
          produce  = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    res.drive_angle   = current_d;
    res.drive_on      = attached_d;
    res.angle_written = written;
    res.position_flag = end_flag_d;
    res.scale_fault   = fault;
  end

  // Output register with a one-word hold stage behind it.
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_res_d   = m_res_q;
    pend_d    = pend_q;
    if (st_q == ST_HOLD) begin
      if (out_free) begin
        m_valid_d = 1'b1;
        m_res_d   = pend_q;
      end
    end else if (produce) begin
      if (out_free) begin
        m_valid_d = 1'b1;
        m_res_d   = res;
      end else begin
        pend_d = res;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= '0;
      lo_limit_q      <= '0;
      hi_limit_q      <= HI_LIMIT_RST;
      neutral_q       <= NEUTRAL_ANGLE_RST;
      value_low_q     <= '0;
      value_high_q    <= VALUE_BITS'(VALUE_HIGH_RST);
      release_ticks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:          mode_q          <= cfg_data_i[MODE_BITS-1:0];
        REG_LO_LIMIT:      lo_limit_q      <= cfg_data_i[ANGLE_BITS-1:0];
        REG_HI_LIMIT:      hi_limit_q      <= cfg_data_i[ANGLE_BITS-1:0];
        REG_NEUTRAL_ANGLE: neutral_q       <= cfg_data_i[ANGLE_BITS-1:0];
        REG_VALUE_LOW:     value_low_q     <= cfg_data_i[VALUE_BITS-1:0];
        REG_VALUE_HIGH:    value_high_q    <= cfg_data_i[VALUE_BITS-1:0];
        REG_RELEASE_TICKS: release_ticks_q <= cfg_data_i[TIMER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Channel state and handshake control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      target_q   <= '0;
      current_q  <= '0;
      attached_q <= 1'b0;
      armed_q    <= 1'b0;
      count_q    <= '0;
      end_flag_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      st_q       <= (produce && !out_free) ? ST_HOLD : st_d;
      target_q   <= target_d;
      current_q  <= current_d;
      attached_q <= attached_d;
      armed_q    <= armed_d;
      count_q    <= count_d;
      end_flag_q <= end_flag_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Result words need no reset; their valid flag guards them.
  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
    pend_q  <= pend_d;
  end

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_BITS - RESULT_BITS){1'b0}}, m_res_q};

  // A parked word only exists while the output register is still full.
  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_HOLD) |-> m_valid_q)
    else $error("hold stage used with an empty output register");

  // A parked word moves out as soon as the output register frees up.
  a_hold_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_HOLD) && m_axis_tready_i) |=> (m_valid_q && (st_q == ST_IDLE)))
    else $error("parked word not moved to the output");

  // The scaling unit reports only for a set value in flight.
  a_scaler_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_done |-> (st_q == ST_SCALE))
    else $error("scaler result without a pending set value");

  // An armed countdown always belongs to an attached drive.
  a_armed_attached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> attached_q)
    else $error("release countdown armed while the drive is released");

endmodule
